// ----- src/cng_pkg.sv -----
// Package for the colored noise generator core: state and code types,
// fixed-point filter coefficients (Q1.30) and the 32-bit saturation helper.
// No dependencies.
package cng_pkg;

  localparam int SAMPLE_WIDTH_DEF = 24;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_COLOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_LEVEL  = 2'd1;

  localparam logic [15:0] GAIN_RESET = 16'hFFFF;

  localparam int NUM_POLES = 6;
  localparam int DIV_ITERS = 4;

  // Shift that takes the white sample to Q22 for the filters
  localparam int FILT_SH = 10;

  typedef enum logic [1:0] {
    COLOR_WHITE  = 2'd0,
    COLOR_PINK   = 2'd1,
    COLOR_BROWN  = 2'd2,
    COLOR_SILENT = 2'd3
  } color_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_GL,
    ST_MAG,
    ST_PRE,
    ST_DIV,
    ST_FIX,
    ST_PK_KEEP,
    ST_PK_FEED,
    ST_PK_SUM,
    ST_PK_DIR,
    ST_PK_DADD,
    ST_PK_DLY,
    ST_PK_GAIN,
    ST_BR_LEAK,
    ST_BR_IN,
    ST_BR_SUM,
    ST_BR_RND,
    ST_BR_X7,
    ST_BR_HALF,
    ST_OUTQ,
    ST_DONE
  } state_t;

  // Rounding shift selection of the shared rounder
  typedef enum logic [1:0] {
    RND_Q30,
    RND_HALF,
    RND_OUT
  } rnd_sel_t;

  localparam logic signed [31:0] POLE_KEEP [NUM_POLES] = '{
    32'sd1072517758, 32'sd1066569229, 32'sd1040455827,
    32'sd930397290,  32'sd590558003,  -32'sd817761773
  };

  localparam logic signed [31:0] POLE_FEED [NUM_POLES] = '{
    32'sd59611891,  32'sd80612134,  32'sd165197327,
    32'sd333381374, 32'sd572253067, -32'sd18144089
  };

  localparam logic signed [31:0] K_DIRECT   = 32'sd575740366;
  localparam logic signed [31:0] K_DELAY    = 32'sd124474595;
  localparam logic signed [31:0] K_PINKGAIN = 32'sd118111601;
  localparam logic signed [31:0] K_LEAK     = 32'sd1052688063;
  localparam logic signed [31:0] K_BROWNIN  = 32'sd21053761;
  localparam logic signed [31:0] K_SEVEN    = 32'sd7;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -40'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

// ----- src/colored_noise_generator_core.sv -----
// One item at a time: in_stall is high from the input transfer until the
// result is loaded into the output register, for every colour.
// Processing time is set by the single shared 36x32 multiplier and rounder, the
// four-step divide by 65535 and, for pink, three steps per filter pole.
// Reset (synchronous, rst_n low): sequencer idle, no result pending, colour
// white, gain full scale, all filter state zero.
module colored_noise_generator_core
  import cng_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_write_en,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [15:0]                    in_envelope_level,
  input  logic [15:0]                    in_random_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample
);

  localparam int OUT_FRAC = SAMPLE_WIDTH - 1;
  localparam int WSH      = 32 - OUT_FRAC;
  localparam int LSH      = (OUT_FRAC >= 22) ? OUT_FRAC - 22 : 0;
  localparam int RSH      = (OUT_FRAC < 22) ? 22 - OUT_FRAC : 1;

  localparam logic [48:0] W_BIAS = 49'd65535 << (WSH - 1);
  localparam logic [48:0] F_BIAS = 49'd65535 << (FILT_SH - 1);

  localparam logic signed [69:0] OUT_BIAS = 70'sd1 <<< (RSH - 1);
  localparam logic signed [47:0] OUT_MAX  = (48'sd1 <<< (SAMPLE_WIDTH - 1)) - 48'sd1;
  localparam logic signed [47:0] OUT_MIN  = -OUT_MAX - 48'sd1;

  function automatic logic signed [SAMPLE_WIDTH-1:0] sat_out(input logic signed [47:0] v);
    if (v > OUT_MAX) begin
      return OUT_MAX[SAMPLE_WIDTH-1:0];
    end else if (v < OUT_MIN) begin
      return OUT_MIN[SAMPLE_WIDTH-1:0];
    end
    return v[SAMPLE_WIDTH-1:0];
  endfunction

  state_t                         state_r, state_nxt;
  color_t                         color_r, color_nxt;
  logic [15:0]                    gain_r, gain_nxt;
  logic [15:0]                    level_r, level_nxt;
  logic [15:0]                    dmag_r, dmag_nxt;
  logic                           dneg_r, dneg_nxt;
  logic signed [67:0]             prod_r, prod_nxt;
  logic [47:0]                    m_r, m_nxt;
  logic [32:0]                    q_r, q_nxt;
  logic [1:0]                     cnt_r, cnt_nxt;
  logic signed [33:0]             white_r, white_nxt;
  logic [2:0]                     i_r, i_nxt;
  logic signed [35:0]             t_r, t_nxt;
  logic signed [31:0]             v_r, v_nxt;
  logic signed [35:0]             acc_r, acc_nxt;
  logic signed [67:0]             s_r, s_nxt;
  logic signed [39:0]             y_r, y_nxt;
  logic signed [SAMPLE_WIDTH-1:0] res_r, res_nxt;
  logic signed [31:0]             pole_r [NUM_POLES];
  logic signed [31:0]             pole_nxt [NUM_POLES];
  logic signed [31:0]             delay_r, delay_nxt;
  logic signed [31:0]             brown_r, brown_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r, out_sample_nxt;

  // shared multiplier operands
  logic signed [35:0] mul_a;
  logic signed [31:0] mul_b;

  // shared rounder
  rnd_sel_t           rnd_sel;
  logic signed [67:0] rnd_src;
  logic signed [35:0] rnd_acc;
  logic signed [69:0] src_x, acc_x, neg_x, rnd_sum, rnd_shf;
  logic signed [39:0] rnd_res;

  // front-end rounding before the divide
  logic [48:0]        pre_sum;
  logic [47:0]        pre_m;
  logic [32:0]        q_fin;
  logic signed [33:0] white_c;
  logic signed [31:0] v_c;

  assign in_stall   = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  // Round-to-nearest, ties away from zero; in Q30 mode an extra Q22 term
  // rides in at bit 30 so it adds after the rounding of the product.
  always_comb begin
    src_x = 70'(rnd_src);
    acc_x = 70'(rnd_acc) <<< 30;
    neg_x = {69'd0, rnd_src[67]};
    case (rnd_sel)
      RND_Q30: begin
        rnd_sum = src_x + acc_x + (70'sd1 <<< 29) - neg_x;
        rnd_shf = rnd_sum >>> 30;
      end
      RND_HALF: begin
        rnd_sum = src_x + 70'sd1 - neg_x;
        rnd_shf = rnd_sum >>> 1;
      end
      RND_OUT: begin
        rnd_sum = src_x + OUT_BIAS - neg_x;
        rnd_shf = rnd_sum >>> RSH;
      end
      default: begin
        rnd_sum = src_x;
        rnd_shf = src_x;
      end
    endcase
    rnd_res = rnd_shf[39:0];
  end

  always_comb begin
    if (color_r == COLOR_WHITE) begin
      pre_sum = 49'(prod_r[47:0]) + W_BIAS;
      pre_m   = 48'(pre_sum >> WSH);
    end else begin
      pre_sum = 49'(prod_r[47:0]) + F_BIAS;
      pre_m   = 48'(pre_sum >> FILT_SH);
    end
    q_fin   = q_r + 33'(m_r >= 48'd65535);
    white_c = dneg_r ? -$signed({1'b0, q_fin}) : $signed({1'b0, q_fin});
    v_c     = sat32(rnd_res);
  end

  always_comb begin
    state_nxt      = state_r;
    color_nxt      = color_r;
    gain_nxt       = gain_r;
    level_nxt      = level_r;
    dmag_nxt       = dmag_r;
    dneg_nxt       = dneg_r;
    m_nxt          = m_r;
    q_nxt          = q_r;
    cnt_nxt        = cnt_r;
    white_nxt      = white_r;
    i_nxt          = i_r;
    t_nxt          = t_r;
    v_nxt          = v_r;
    acc_nxt        = acc_r;
    s_nxt          = s_r;
    y_nxt          = y_r;
    res_nxt        = res_r;
    pole_nxt       = pole_r;
    delay_nxt      = delay_r;
    brown_nxt      = brown_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_sample_nxt = out_sample_r;
    mul_a          = '0;
    mul_b          = '0;
    rnd_sel        = RND_Q30;
    rnd_src        = prod_r;
    rnd_acc        = '0;

    if (cfg_write_en) begin
      case (cfg_index)
        REG_NOISE_COLOR: color_nxt = color_t'(cfg_data[1:0]);
        REG_GAIN_LEVEL:  gain_nxt  = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          level_nxt = in_envelope_level;
          // 65535 - 2r kept as sign and magnitude
          dneg_nxt  = in_random_word[15];
          if (in_random_word[15]) begin
            dmag_nxt = 16'({in_random_word, 1'b0} - 17'd65535);
          end else begin
            dmag_nxt = 16'(17'd65535 - {in_random_word, 1'b0});
          end
          state_nxt = ST_GL;
        end
      end
      ST_GL: begin
        mul_a     = 36'(gain_r);
        mul_b     = 32'(level_r);
        state_nxt = ST_MAG;
      end
      ST_MAG: begin
        mul_a     = 36'(prod_r[31:0]);
        mul_b     = 32'(dmag_r);
        state_nxt = ST_PRE;
      end
      ST_PRE: begin
        m_nxt     = pre_m;
        q_nxt     = '0;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // m = h*65536 + l = h*65535 + (h + l)
        m_nxt   = 48'(m_r[47:16]) + 48'(m_r[15:0]);
        q_nxt   = q_r + 33'(m_r[47:16]);
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'(DIV_ITERS - 1)) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        white_nxt = white_c;
        case (color_r)
          COLOR_WHITE: begin
            res_nxt   = sat_out(48'(white_c));
            state_nxt = ST_DONE;
          end
          COLOR_PINK: begin
            acc_nxt   = 36'(delay_r);
            i_nxt     = '0;
            state_nxt = ST_PK_KEEP;
          end
          COLOR_BROWN: begin
            state_nxt = ST_BR_LEAK;
          end
          default: begin
            res_nxt   = '0;
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_PK_KEEP: begin
        mul_a = 36'(pole_r[i_r]);
        mul_b = POLE_KEEP[i_r];
        if (i_r != 3'd0) begin
          acc_nxt = acc_r + 36'(v_r);
        end
        state_nxt = ST_PK_FEED;
      end
      ST_PK_FEED: begin
        t_nxt     = rnd_res[35:0];
        mul_a     = 36'(white_r);
        mul_b     = POLE_FEED[i_r];
        state_nxt = ST_PK_SUM;
      end
      ST_PK_SUM: begin
        rnd_acc        = t_r;
        v_nxt          = v_c;
        pole_nxt[i_r]  = v_c;
        if (i_r == 3'(NUM_POLES - 1)) begin
          state_nxt = ST_PK_DIR;
        end else begin
          i_nxt     = i_r + 3'd1;
          state_nxt = ST_PK_KEEP;
        end
      end
      ST_PK_DIR: begin
        acc_nxt   = acc_r + 36'(v_r);
        mul_a     = 36'(white_r);
        mul_b     = K_DIRECT;
        state_nxt = ST_PK_DADD;
      end
      ST_PK_DADD: begin
        rnd_acc   = acc_r;
        acc_nxt   = rnd_res[35:0];
        mul_a     = 36'(white_r);
        mul_b     = K_DELAY;
        state_nxt = ST_PK_DLY;
      end
      ST_PK_DLY: begin
        delay_nxt = v_c;
        mul_a     = acc_r;
        mul_b     = K_PINKGAIN;
        state_nxt = ST_PK_GAIN;
      end
      ST_PK_GAIN: begin
        y_nxt     = rnd_res;
        state_nxt = ST_OUTQ;
      end
      ST_BR_LEAK: begin
        mul_a     = 36'(brown_r);
        mul_b     = K_LEAK;
        state_nxt = ST_BR_IN;
      end
      ST_BR_IN: begin
        s_nxt     = prod_r;
        mul_a     = 36'(white_r);
        mul_b     = K_BROWNIN;
        state_nxt = ST_BR_SUM;
      end
      ST_BR_SUM: begin
        // both products summed exactly, rounded once
        s_nxt     = s_r + prod_r;
        state_nxt = ST_BR_RND;
      end
      ST_BR_RND: begin
        rnd_src   = s_r;
        brown_nxt = v_c;
        state_nxt = ST_BR_X7;
      end
      ST_BR_X7: begin
        mul_a     = 36'(brown_r);
        mul_b     = K_SEVEN;
        state_nxt = ST_BR_HALF;
      end
      ST_BR_HALF: begin
        rnd_sel   = RND_HALF;
        y_nxt     = rnd_res;
        state_nxt = ST_OUTQ;
      end
      ST_OUTQ: begin
        // Q22 to output scale
        rnd_sel = RND_OUT;
        rnd_src = 68'(y_r);
        if (OUT_FRAC >= 22) begin
          res_nxt = sat_out(48'(y_r) <<< LSH);
        end else begin
          res_nxt = sat_out(48'(rnd_res));
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = res_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    prod_nxt = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      color_r     <= COLOR_WHITE;
      gain_r      <= GAIN_RESET;
      out_valid_r <= 1'b0;
      delay_r     <= '0;
      brown_r     <= '0;
      for (int k = 0; k < NUM_POLES; k++) begin
        pole_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      color_r     <= color_nxt;
      gain_r      <= gain_nxt;
      out_valid_r <= out_valid_nxt;
      delay_r     <= delay_nxt;
      brown_r     <= brown_nxt;
      pole_r      <= pole_nxt;
    end
  end

  always_ff @(posedge clk) begin
    level_r      <= level_nxt;
    dmag_r       <= dmag_nxt;
    dneg_r       <= dneg_nxt;
    prod_r       <= prod_nxt;
    m_r          <= m_nxt;
    q_r          <= q_nxt;
    cnt_r        <= cnt_nxt;
    white_r      <= white_nxt;
    i_r          <= i_nxt;
    t_r          <= t_nxt;
    v_r          <= v_nxt;
    acc_r        <= acc_nxt;
    s_r          <= s_nxt;
    y_r          <= y_nxt;
    res_r        <= res_nxt;
    out_sample_r <= out_sample_nxt;
  end

endmodule

// ----- dv/tb_colored_noise_generator_core.sv -----
// Self-checking testbench for colored_noise_generator_core: directed table, then random
// phases over all colours and gains, with random idling on both channels and one long hold.
// Depends on cng_pkg and the core only.
module tb_colored_noise_generator_core;
  import cng_pkg::*;

  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam longint Q30 = 64'sd1073741824;
  localparam int SETTLE_CYCLES = 40;    // longest latency (pink) plus margin
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;    // cycles with no transfer before giving up
  localparam int PHASES = 20;
  localparam int ITEMS_PER_PHASE = 60;

  // Indexes beyond the register list; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  // Kellet filter coefficients, Q1.30
  localparam longint KEEP_Q30 [6] = '{
    64'sd1072517758, 64'sd1066569229, 64'sd1040455827,
    64'sd930397290, 64'sd590558003, -64'sd817761773
  };
  localparam longint FEED_Q30 [6] = '{
    64'sd59611891, 64'sd80612134, 64'sd165197327,
    64'sd333381374, 64'sd572253067, -64'sd18144089
  };
  localparam longint DIRECT_Q30 = 64'sd575740366;
  localparam longint DELAY_Q30 = 64'sd124474595;
  localparam longint PINK_GAIN_Q30 = 64'sd118111601;
  localparam longint LEAK_Q30 = 64'sd1052688063;   // 1/1.02
  localparam longint BROWN_IN_Q30 = 64'sd21053761; // 0.02/1.02

  typedef struct packed {
    logic [15:0] color_wr;
    logic [15:0] gain_wr;
    logic [15:0] lvl;
    logic [15:0] rw;
    logic typed;
    logic signed [SW-1:0] want;
  } noise_row_t;

  localparam int DIR_ROWS = 23;
  localparam noise_row_t DIR_TAB [DIR_ROWS] = '{
    // reset config: white, full gain
    '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1, 24'sd8388352},
    '{16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, -24'sd8388352},
    '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h7FFF, 1'b1, 24'sd128},
    '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h8000, 1'b1, -24'sd128},
    '{16'h0000, 16'hFFFF, 16'h0000, 16'h1234, 1'b1, 24'sd0},
    '{16'h0000, 16'hFFFF, 16'h8000, 16'h5555, 1'b0, 24'sd0},
    '{16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 1'b1, 24'sd0},
    '{16'h0000, 16'h8000, 16'h8000, 16'hAAAA, 1'b0, 24'sd0},
    // silent, then silent again with the upper bits of the write set
    '{16'h0003, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1, 24'sd0},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 24'sd0},
    // pink
    '{16'h0001, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 24'sd0},
    '{16'h0001, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 24'sd0},
    '{16'h0001, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 24'sd0},
    '{16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 24'sd0},
    '{16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 24'sd0},
    '{16'h0001, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, 24'sd0},
    // brown, written as FFFE to check masking
    '{16'hFFFE, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 24'sd0},
    '{16'hFFFE, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 24'sd0},
    '{16'hFFFE, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 24'sd0},
    '{16'hFFFE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 24'sd0},
    '{16'hFFFE, 16'hFFFF, 16'h7FFF, 16'h8000, 1'b0, 24'sd0},
    // pink state must have survived the brown stretch
    '{16'h0001, 16'hFFFF, 16'hC000, 16'h5555, 1'b0, 24'sd0},
    '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1, 24'sd8388352}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] in_envelope_level = '0;
  logic [15:0] in_random_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SW-1:0] out_sample;

  // Typed expectation travelling with the item on the input channel
  logic row_typed = 1'b0;
  logic signed [SW-1:0] row_want = '0;

  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  int err_count = 0;
  int quiet_cycles = 0;

  // Predictor copy of the block's registers and filter state
  color_t color_reg = COLOR_WHITE;
  logic [15:0] gain_reg = GAIN_RESET;
  longint pole_q22 [6];
  longint delay_q22 = 0;
  longint brown_q22 = 0;

  logic signed [SW-1:0] samples_due [$];
  logic signed [SW-1:0] pred, due;

  colored_noise_generator_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_envelope_level(in_envelope_level),
    .in_random_word(in_random_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_sample(out_sample)
  );

  always #5 clk = ~clk;

  // Round to nearest, ties away from zero; d > 0
  function automatic longint div_near(longint x, longint d);
    longint mag, q;
    mag = (x < 0) ? -x : x;
    q = (mag + d / 2) / d;
    return (x < 0) ? -q : q;
  endfunction

  function automatic longint clamp(longint x, int bits);
    longint hi, lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return (x > hi) ? hi : ((x < lo) ? lo : x);
  endfunction

  function automatic longint mul_q30(longint v, longint k);
    return div_near(v * k, Q30);
  endfunction

  // Q22 to Q1.23 output scale, saturated
  function automatic longint q22_out(longint v);
    return clamp(v * 2, SW);
  endfunction

  function automatic logic signed [SW-1:0] next_sample(logic [15:0] lvl, logic [15:0] rw);
    longint num, w22, acc, v, res;
    int i;
    num = longint'(gain_reg) * longint'(lvl) * (64'sd65535 - 2 * longint'(rw));
    w22 = div_near(num, 64'sd65535 * 1024);
    res = 0;
    case (color_reg)
      COLOR_WHITE: begin
        res = clamp(div_near(num, 64'sd65535 * 512), SW);
      end
      COLOR_PINK: begin
        acc = 0;
        for (i = 0; i < 6; i++) begin
          v = mul_q30(pole_q22[i], KEEP_Q30[i]) + mul_q30(w22, FEED_Q30[i]);
          pole_q22[i] = clamp(v, 32);
          acc += pole_q22[i];
        end
        // delay term uses last sample's value, updated after the sum
        acc += delay_q22 + mul_q30(w22, DIRECT_Q30);
        res = q22_out(mul_q30(acc, PINK_GAIN_Q30));
        delay_q22 = clamp(mul_q30(w22, DELAY_Q30), 32);
      end
      COLOR_BROWN: begin
        brown_q22 = clamp(div_near(brown_q22 * LEAK_Q30 + w22 * BROWN_IN_Q30, Q30), 32);
        res = q22_out(div_near(brown_q22 * 7, 2));
      end
      default: res = 0;
    endcase
    return res[SW-1:0];
  endfunction

  // Scoreboard and watchdog, sampling pre-edge values
  always @(posedge clk) begin
    if (!rst_n) begin
      color_reg = COLOR_WHITE;
      gain_reg = GAIN_RESET;
      for (int i = 0; i < 6; i++) pole_q22[i] = 0;
      delay_q22 = 0;
      brown_q22 = 0;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          REG_NOISE_COLOR: color_reg = color_t'(cfg_data[1:0]);
          REG_GAIN_LEVEL: gain_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        pred = next_sample(in_envelope_level, in_random_word);
        samples_due.push_back(row_typed ? row_want : pred);
      end
      if (out_valid && !out_stall) begin
        if (samples_due.size() == 0) begin
          $error("sample: no transfer expected, got %0d", out_sample);
          err_count++;
        end else begin
          due = samples_due.pop_front();
          if (out_sample !== due) begin
            $error("sample: expected %0d, got %0d", due, out_sample);
            err_count++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Receiver: random stall, plus one long hold on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic push_item(input logic [15:0] lvl, input logic [15:0] rw, input logic typed,
                           input logic signed [SW-1:0] want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_envelope_level <= lvl;
    in_random_word <= rw;
    row_typed <= typed;
    row_want <= want;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (samples_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [15:0] color_wr, input logic [15:0] gain_wr);
    drain();
    set_reg(REG_NOISE_COLOR, color_wr);
    set_reg(REG_GAIN_LEVEL, gain_wr);
    cfg_write_en <= 1'b0;
  endtask

  function automatic logic [15:0] corner_value();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h7FFF;
      3: return 16'h8000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    logic [15:0] last_color, last_gain, lvl, rw, dc_rw, gain;
    int n, seg, len;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Writes outside the register list must leave the reset values alone
    set_reg(REG_SPARE_2, 16'hFFFF);
    set_reg(REG_SPARE_3, 16'h0000);
    cfg_write_en <= 1'b0;
    @(negedge clk);

    last_color = 16'h0000;
    last_gain = GAIN_RESET;
    foreach (DIR_TAB[r]) begin
      if (DIR_TAB[r].color_wr != last_color || DIR_TAB[r].gain_wr != last_gain) begin
        program_regs(DIR_TAB[r].color_wr, DIR_TAB[r].gain_wr);
        last_color = DIR_TAB[r].color_wr;
        last_gain = DIR_TAB[r].gain_wr;
      end
      push_item(DIR_TAB[r].lvl, DIR_TAB[r].rw, DIR_TAB[r].typed, DIR_TAB[r].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 5)
        0: gain = 16'hFFFF;
        1: gain = 16'h0000;
        2: gain = 16'($urandom_range(49152, 65535));
        default: gain = 16'($urandom_range(0, 65535));
      endcase
      program_regs({14'($urandom_range(0, 16383)), 2'((ph + ph / 4) % 4)}, gain);
      case (ph % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 62; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 62; end
        default: begin send_idle_pct = 33; stall_pct = 33; end
      endcase
      // Long receiver hold while the sender keeps offering transfers
      if (ph == 4) hold_req = 1'b1;
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        seg = $urandom_range(0, 9);
        len = $urandom_range(4, 30);
        dc_rw = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        for (int k = 0; k < len && n < ITEMS_PER_PHASE; k++) begin
          if (seg < 4) begin
            lvl = 16'($urandom_range(0, 65535));
            rw = 16'($urandom_range(0, 65535));
          end else if (seg < 7) begin
            // sustained one-sided input drives the filters into saturation
            lvl = $urandom_range(0, 7) == 0 ? 16'($urandom_range(32768, 65535)) : 16'hFFFF;
            rw = dc_rw ^ 16'($urandom_range(0, 255));
          end else begin
            lvl = corner_value();
            rw = corner_value();
          end
          push_item(lvl, rw, 1'b0, '0);
          n++;
        end
      end
    end

    drain();
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
